@@ hw/rtl/trial_division_factorizer_unit_assert.svh @@
// assertion helpers shared by the factorizer rtl
`ifndef TRIAL_DIVISION_FACTORIZER_UNIT_ASSERT_SVH
`define TRIAL_DIVISION_FACTORIZER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TDF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tdf assertion failed");

// next-cycle implication, checked out of reset
`define TDF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tdf assertion failed");

`endif

@@ hw/rtl/tdf_pkg.sv @@
package tdf_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_EVAL
    } state_t;

endpackage

@@ hw/rtl/trial_division_factorizer_unit.sv @@
// Prime factorizer by trial division.
// Input channel: number with item_valid/item_ready; one beat is one integer.
// Output channel: factor and last with result_valid/result_ready; one beat per
// prime factor, ascending, repeats included; last marks the final factor.
// Inputs 0 and 1 come back unchanged as a single beat with last set.
// A single restoring divider, one quotient bit per cycle, tests each trial
// divisor d: it yields rem/d and rem%d, and d > rem/d ends the search.
// Each divisor tried and each factor found costs a full divider pass and then
// the evaluation state; a 31-bit prime tries about 46341 divisors.
// item_ready is high only while the sequencer is idle; the final factor sits
// in the output register, so the next item is taken while it waits.
// A stalled receiver holds the sequencer at its next factor until the output
// register frees up; no beat is lost.
// Reset clears the sequencer and the output valid; no item is in flight.
module trial_division_factorizer_unit #(
    parameter int NUMBER_BITS = 31
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  logic [NUMBER_BITS-1:0] number,
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic [NUMBER_BITS-1:0] factor,
    output logic                   last
);

    localparam int CNT_BITS = $clog2(NUMBER_BITS);
    localparam logic [NUMBER_BITS-1:0] FIRST_DIVISOR = NUMBER_BITS'(2);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(NUMBER_BITS - 1);

    tdf_pkg::state_t state_reg, state_next;

    logic [NUMBER_BITS-1:0] rem_reg, rem_next;
    logic [NUMBER_BITS-1:0] d_reg, d_next;
    logic [NUMBER_BITS-1:0] quo_reg, quo_next;
    logic [NUMBER_BITS-1:0] part_reg, part_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [NUMBER_BITS-1:0] factor_reg, factor_next;
    logic                   last_reg, last_next;
    logic                   result_valid_reg, result_valid_next;

    logic                   accept;
    logic                   slot_free;
    logic                   small_in;
    logic                   div_done;
    logic                   eval_done;
    logic                   eval_hit;
    logic [NUMBER_BITS:0]   trial;
    logic [NUMBER_BITS:0]   trial_diff;
    logic                   trial_ge;

    assign item_ready   = (state_reg == tdf_pkg::S_IDLE);
    assign accept       = item_valid && item_ready;
    assign slot_free    = !result_valid_reg || result_ready;
    assign small_in     = (rem_reg < FIRST_DIVISOR);
    assign div_done     = (cnt_reg == '0);
    assign eval_done    = (d_reg > quo_reg);
    assign eval_hit     = (part_reg == '0);

    // shared divider step: bring down the next dividend bit
    assign trial      = {part_reg, quo_reg[NUMBER_BITS-1]};
    assign trial_diff = trial - {1'b0, d_reg};
    assign trial_ge   = (trial >= {1'b0, d_reg});

    assign result_valid = result_valid_reg;
    assign factor       = factor_reg;
    assign last         = last_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tdf_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = tdf_pkg::S_START;
                end
            end
            tdf_pkg::S_START:
            begin
                if (!small_in)
                begin
                    state_next = tdf_pkg::S_DIV;
                end
                else if (slot_free)
                begin
                    state_next = tdf_pkg::S_IDLE;
                end
            end
            tdf_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    state_next = tdf_pkg::S_EVAL;
                end
            end
            tdf_pkg::S_EVAL:
            begin
                if (eval_done)
                begin
                    if (slot_free)
                    begin
                        state_next = tdf_pkg::S_IDLE;
                    end
                end
                else if (!eval_hit || slot_free)
                begin
                    state_next = tdf_pkg::S_DIV;
                end
            end
            default:
            begin
                state_next = tdf_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rem_next          = rem_reg;
        d_next            = d_reg;
        quo_next          = quo_reg;
        part_next         = part_reg;
        cnt_next          = cnt_reg;
        factor_next       = factor_reg;
        last_next         = last_reg;
        result_valid_next = result_valid_reg && !result_ready;
        case (state_reg)
            tdf_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    rem_next = number;
                    d_next   = FIRST_DIVISOR;
                end
            end
            tdf_pkg::S_START:
            begin
                if (!small_in)
                begin
                    quo_next  = rem_reg;
                    part_next = '0;
                    cnt_next  = CNT_LAST;
                end
                else if (slot_free)
                begin
                    factor_next       = rem_reg;
                    last_next         = 1'b1;
                    result_valid_next = 1'b1;
                end
            end
            tdf_pkg::S_DIV:
            begin
                if (trial_ge)
                begin
                    part_next = trial_diff[NUMBER_BITS-1:0];
                end
                else
                begin
                    part_next = trial[NUMBER_BITS-1:0];
                end
                quo_next = {quo_reg[NUMBER_BITS-2:0], trial_ge};
                if (!div_done)
                begin
                    cnt_next = cnt_reg - CNT_BITS'(1);
                end
            end
            tdf_pkg::S_EVAL:
            begin
                if (eval_done)
                begin
                    // no divisor left up to the square root: remainder is prime
                    if (slot_free)
                    begin
                        factor_next       = rem_reg;
                        last_next         = 1'b1;
                        result_valid_next = 1'b1;
                    end
                end
                else if (eval_hit)
                begin
                    // divides evenly: emit d, keep it, divide again
                    if (slot_free)
                    begin
                        factor_next       = d_reg;
                        last_next         = 1'b0;
                        result_valid_next = 1'b1;
                        rem_next          = quo_reg;
                        quo_next          = quo_reg;
                        part_next         = '0;
                        cnt_next          = CNT_LAST;
                    end
                end
                else
                begin
                    d_next    = d_reg + NUMBER_BITS'(1);
                    quo_next  = rem_reg;
                    part_next = '0;
                    cnt_next  = CNT_LAST;
                end
            end
            default:
            begin
                result_valid_next = result_valid_reg && !result_ready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tdf_pkg::S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        d_reg      <= d_next;
        quo_reg    <= quo_next;
        part_reg   <= part_next;
        cnt_reg    <= cnt_next;
        factor_reg <= factor_next;
        last_reg   <= last_next;
    end

`include "trial_division_factorizer_unit_assert.svh"

    `TDF_ASSERT_NEXT(a_div_holds_divisor, state_reg == tdf_pkg::S_DIV, d_reg == $past(d_reg))
    `TDF_ASSERT_NOW(a_divisor_min,
        state_reg == tdf_pkg::S_DIV || state_reg == tdf_pkg::S_EVAL, d_reg >= FIRST_DIVISOR)
    `TDF_ASSERT_NOW(a_rem_min,
        state_reg == tdf_pkg::S_DIV || state_reg == tdf_pkg::S_EVAL, rem_reg >= FIRST_DIVISOR)
    `TDF_ASSERT_NOW(a_eval_after_full_div, state_reg == tdf_pkg::S_EVAL, cnt_reg == '0)

endmodule

@@ test/tb_trial_division_factorizer_unit.sv @@
module tb_trial_division_factorizer_unit;

    localparam int NB = 31;
    localparam longint unsigned NUMBER_SPAN = 64'd1 << NB;
    localparam int STALL_LIMIT = 6000000;
    localparam int HOLDOFF_CYCLES = 300;

    typedef struct packed {
        logic [NB-1:0] factor;
        logic          last;
    } factor_beat_t;

    logic          clk;
    logic          rst_n;
    logic          item_valid;
    logic          item_ready;
    logic [NB-1:0] number;
    logic          result_valid;
    logic          result_ready;
    logic [NB-1:0] factor;
    logic          last;

    factor_beat_t pending_factors[$];
    int           mismatches;
    int           stall_cycles;
    bit           steady;
    bit           hold_results;

    trial_division_factorizer_unit #(
        .NUMBER_BITS(NB)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .number      (number),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .factor      (factor),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // expected beats for one number: trial divisors from 2 while d*d <= remainder
    function automatic void push_prime_factors(input logic [NB-1:0] value);
        longint unsigned remainder;
        longint unsigned divisor;
        remainder = value;
        divisor = 2;
        if (remainder < 2)
        begin
            pending_factors.push_back('{factor: value, last: 1'b1});
            return;
        end
        while (divisor <= remainder / divisor)
        begin
            if (remainder % divisor == 0)
            begin
                pending_factors.push_back('{factor: divisor[NB-1:0], last: 1'b0});
                remainder = remainder / divisor;
            end
            else
            begin
                divisor++;
            end
        end
        pending_factors.push_back('{factor: remainder[NB-1:0], last: 1'b1});
    endfunction

    // product of random small factors, so the largest prime stays cheap to find
    function automatic logic [NB-1:0] random_composite();
        longint unsigned product;
        longint unsigned multiplier;
        int picks;
        product = 1;
        picks = $urandom_range(1, 14);
        repeat (picks)
        begin
            case ($urandom_range(0, 3))
                0: multiplier = $urandom_range(2, 7);
                1: multiplier = $urandom_range(2, 64);
                2: multiplier = $urandom_range(2, 4000);
                default: multiplier = $urandom_range(2, 40000);
            endcase
            if (product * multiplier < NUMBER_SPAN)
                product = product * multiplier;
        end
        return product[NB-1:0];
    endfunction

    task automatic send_number(input logic [NB-1:0] value);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push_prime_factors(value);
        item_valid <= 1'b1;
        number     <= value;
        do @(posedge clk); while (!item_ready);
    endtask

    // receiver: random stalls, optional long holdoff, checks every beat
    initial
    begin
        int gap;
        factor_beat_t want;
        result_ready = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0 || hold_results)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
                while (hold_results) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
            if (pending_factors.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected beat factor=%0d last=%0d", $time, factor, last);
            end
            else
            begin
                want = pending_factors.pop_front();
                if (factor !== want.factor)
                begin
                    mismatches++;
                    $display("%0t: factor expected %0d actual %0d",
                             $time, want.factor, factor);
                end
                if (last !== want.last)
                begin
                    mismatches++;
                    $display("%0t: last expected %0d actual %0d", $time, want.last, last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, stall_cycles);
                $display("tb_trial_division_factorizer_unit: FAIL");
                $finish;
            end
        end
    end

    task automatic test_zero_and_one();
        send_number('0);
        send_number(31'd1);
    endtask

    task automatic test_primes();
        send_number(31'd2);
        send_number(31'd3);
        send_number(31'd5);
        send_number(31'd7);
        send_number(31'd4093);
        send_number(31'd65521);
    endtask

    task automatic test_powers_and_extremes();
        send_number(31'd4);
        send_number(31'd1 << 30);          // thirty beats of 2
        send_number(31'd1162261467);       // 3^19
        send_number(31'd994009);           // square of a prime
        send_number(31'd2147483646);       // every bit but the lsb set
        send_number(31'd2147483640);
        send_number(31'd30030);
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        repeat (8) send_number(random_composite());
        steady = 1'b0;
    endtask

    // receiver stalls long while items keep coming, input side must back up
    task automatic test_receiver_holdoff();
        fork
            begin
                hold_results <= 1'b1;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
                hold_results <= 1'b0;
            end
        join_none
        send_number(31'd1 << 30);
        repeat (6) send_number(random_composite());
    endtask

    task automatic test_random_numbers();
        repeat (70)
        begin
            case ($urandom_range(0, 9))
                0: send_number(NB'($urandom_range(0, 1)));
                1, 2: send_number(NB'($urandom_range(0, 200000)));
                default: send_number(random_composite());
            endcase
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        number       = '0;
        mismatches   = 0;
        stall_cycles = 0;
        steady       = 1'b0;
        hold_results = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_zero_and_one();
        test_primes();
        test_powers_and_extremes();
        test_back_to_back();
        test_receiver_holdoff();
        test_random_numbers();
        item_valid <= 1'b0;

        while (pending_factors.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("tb_trial_division_factorizer_unit: PASS");
        else
            $display("tb_trial_division_factorizer_unit: FAIL");
        $finish;
    end

endmodule
